// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, ck, rn, ante, cons)
`define ASSERT_NEXT(name, ck, rn, ante, cons)
`endif

`endif

// ===== src/bmoc_pkg.sv =====
// types, codes and constants of the bitmask overlap counter
`default_nettype none

package bmoc_pkg;

    localparam int MAX_DIM_DEF = 64;

    localparam int FUNC_W    = 2;
    localparam int COORD_W   = 6;
    localparam int OFS_W     = 8;
    localparam int DIM_W     = 7;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int BOUND_W   = 10;

    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_HEIGHT = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic write_a;
        logic write_b;
        logic start;
        logic load_zero;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last_row;
        logic pipe_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== src/bmoc_ram.sv =====
// generic single-port-write ram with bit write enables and registered read
`default_nettype none

module bmoc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [WIDTH-1:0]         wmask,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/bmoc_datapath.sv =====
// mask stores, overlap bounds, row pipeline and count accumulator
`default_nettype none

module bmoc_datapath
    import bmoc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [DIM_W-1:0]          cfg_data,
    input  logic [COORD_W-1:0]        col,
    input  logic [COORD_W-1:0]        row,
    input  logic                      bit_value,
    input  logic signed [OFS_W-1:0]   offset_x,
    input  logic signed [OFS_W-1:0]   offset_y,
    input  cmd_t                      cmd,
    output status_t                   status,
    output logic [COUNT_W-1:0]        overlap_count
);

    localparam int AW      = $clog2(MAX_DIM);
    localparam int GROUPS  = (MAX_DIM + 7) / 8;
    localparam int WORD_W  = GROUPS * 8;
    localparam int PC_W    = $clog2(MAX_DIM + 1);

    function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

    // configuration
    logic [DIM_W-1:0] a_width_reg, a_height_reg, b_width_reg, b_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_width_reg  <= DIM_RESET;
            a_height_reg <= DIM_RESET;
            b_width_reg  <= DIM_RESET;
            b_height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_A_WIDTH:  a_width_reg  <= cfg_data;
                CFG_A_HEIGHT: a_height_reg <= cfg_data;
                CFG_B_WIDTH:  b_width_reg  <= cfg_data;
                CFG_B_HEIGHT: b_height_reg <= cfg_data;
                default:      a_width_reg  <= a_width_reg;
            endcase
        end
    end

    // overlap bounds in a's coordinates
    logic signed [BOUND_W-1:0] ox_s, oy_s, aw_s, ah_s, bw_s, bh_s;
    logic signed [BOUND_W-1:0] x0, y0, x_end, y_end, x1, y1, y_last, l_first, ox_abs;
    logic [MAX_DIM-1:0]        cols_next;

    always_comb
    begin
        ox_s    = signed'({{(BOUND_W-OFS_W){offset_x[OFS_W-1]}}, offset_x});
        oy_s    = signed'({{(BOUND_W-OFS_W){offset_y[OFS_W-1]}}, offset_y});
        aw_s    = signed'({{(BOUND_W-DIM_W){1'b0}}, dim_sat(a_width_reg)});
        ah_s    = signed'({{(BOUND_W-DIM_W){1'b0}}, dim_sat(a_height_reg)});
        bw_s    = signed'({{(BOUND_W-DIM_W){1'b0}}, dim_sat(b_width_reg)});
        bh_s    = signed'({{(BOUND_W-DIM_W){1'b0}}, dim_sat(b_height_reg)});
        x0      = (ox_s > 0) ? ox_s : '0;
        y0      = (oy_s > 0) ? oy_s : '0;
        x_end   = ox_s + bw_s;
        y_end   = oy_s + bh_s;
        x1      = (x_end < aw_s) ? x_end : aw_s;
        y1      = (y_end < ah_s) ? y_end : ah_s;
        y_last  = y1 - BOUND_W'(1);
        l_first = y0 - oy_s;
        ox_abs  = ox_s[BOUND_W-1] ? -ox_s : ox_s;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            cols_next[i] = (signed'(BOUND_W'(i)) >= x0) && (signed'(BOUND_W'(i)) < x1);
        end
    end

    assign status.empty = (x1 <= x0) || (y1 <= y0);

    // mask stores
    logic               wr_in_range;
    logic [MAX_DIM-1:0] wmask, wdata, rdata_a, rdata_b;
    logic [AW-1:0]      a_row_reg, b_row_reg, last_reg, sh_amt_reg;
    logic               sh_left_reg;
    logic [MAX_DIM-1:0] cols_reg;

    assign wr_in_range = (7'(col) < 7'(MAX_DIM)) && (7'(row) < 7'(MAX_DIM));
    assign wmask = wr_in_range ? ({{(MAX_DIM-1){1'b0}}, 1'b1} << col) : '0;
    assign wdata = {MAX_DIM{bit_value}};

    bmoc_ram #(
        .WIDTH (MAX_DIM),
        .DEPTH (MAX_DIM)
    ) u_ram_a (
        .clk   (clk),
        .we    (cmd.write_a),
        .waddr (row[AW-1:0]),
        .wdata (wdata),
        .wmask (wmask),
        .raddr (a_row_reg),
        .rdata (rdata_a)
    );

    bmoc_ram #(
        .WIDTH (MAX_DIM),
        .DEPTH (MAX_DIM)
    ) u_ram_b (
        .clk   (clk),
        .we    (cmd.write_b),
        .waddr (row[AW-1:0]),
        .wdata (wdata),
        .wmask (wmask),
        .raddr (b_row_reg),
        .rdata (rdata_b)
    );

    // row walk
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_row_reg   <= y0[AW-1:0];
            b_row_reg   <= l_first[AW-1:0];
            last_reg    <= y_last[AW-1:0];
            sh_amt_reg  <= ox_abs[AW-1:0];
            sh_left_reg <= !ox_s[BOUND_W-1];
            cols_reg    <= cols_next;
        end
        else if (cmd.step)
        begin
            a_row_reg <= a_row_reg + AW'(1);
            b_row_reg <= b_row_reg + AW'(1);
        end
    end

    assign status.last_row = (a_row_reg == last_reg);

    // row pipeline: and, per-byte counts, accumulate
    logic                v1_reg, v2_reg, v3_reg;
    logic [MAX_DIM-1:0]  placed, word_next;
    logic [WORD_W-1:0]   word_reg;
    logic [3:0]          grp_next [GROUPS];
    logic [3:0]          grp_reg  [GROUPS];
    logic [PC_W-1:0]     row_sum;
    logic [COUNT_W-1:0]  acc_reg, acc_next, count_reg;

    always_comb
    begin
        placed    = sh_left_reg ? (rdata_b << sh_amt_reg) : (rdata_b >> sh_amt_reg);
        word_next = rdata_a & placed & cols_reg;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                grp_next[g] = grp_next[g] + 4'(word_reg[g*8+b]);
            end
        end
        row_sum = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            row_sum = row_sum + PC_W'(grp_reg[g]);
        end
        acc_next = acc_reg + COUNT_W'(row_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            word_reg <= WORD_W'(word_next);
        end
        if (v2_reg)
        begin
            grp_reg <= grp_next;
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load_zero)
        begin
            count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg <= acc_reg;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign overlap_count    = count_reg;

endmodule

`default_nettype wire

// ===== src/bmoc_ctrl.sv =====
// control state machine: beat acceptance, row scan sequencing, result register valid
`default_nettype none

module bmoc_ctrl
    import bmoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [FUNC_W-1:0] func,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  status_t           status,
    output cmd_t              cmd
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept, is_compute;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign is_compute = (func == FUNC_COMPUTE);
    assign accept     = req_valid && !req_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_compute && !status.empty)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_row)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        req_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall     = rsp_valid_reg && is_compute;
                cmd.write_a   = accept && (func == FUNC_WRITE_A);
                cmd.write_b   = accept && (func == FUNC_WRITE_B);
                cmd.start     = accept && is_compute && !status.empty;
                cmd.load_zero = accept && is_compute && status.empty;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.finish = !status.pipe_busy;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
        rsp_valid_next = (rsp_valid_reg && rsp_stall) || cmd.finish || cmd.load_zero;
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== src/bitmask_overlap_counter_top.sv =====
// top level of the bitmask overlap counter
`default_nettype none
`include "assert_macros.svh"

// Holds two 1-bit masks of up to MAX_DIM x MAX_DIM in two row memories. A write beat
// (func 0 or 1) sets one bit and is taken every cycle when idle. A compute beat
// (func 2) places mask B at (offset_x, offset_y) over mask A and returns the number of
// pixels set in both inside the intersection of the two rectangles. An empty overlap
// gives its result in the cycle after the beat; otherwise the controller walks the
// overlap rows (at most MAX_DIM) one per cycle through the memory read ports and a
// four-stage row pipeline (read, and, byte counts, accumulate), and the result
// appears once the pipeline has drained. The next beat is taken when the result
// appears; a further compute beat waits while a result is still held in the output
// register. Mask memories are not cleared: read only bits that were written.
module bitmask_overlap_counter_top
    import bmoc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DIM_W-1:0]        cfg_data,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [FUNC_W-1:0]       func,
    input  logic [COORD_W-1:0]      col,
    input  logic [COORD_W-1:0]      row,
    input  logic                    bit_value,
    input  logic signed [OFS_W-1:0] offset_x,
    input  logic signed [OFS_W-1:0] offset_y,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [COUNT_W-1:0]      overlap_count
);

    cmd_t    cmd;
    status_t status;

    bmoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (func),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bmoc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .col           (col),
        .row           (row),
        .bit_value     (bit_value),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .cmd           (cmd),
        .status        (status),
        .overlap_count (overlap_count)
    );

    `ASSERT_IMPLIES(a_mask_write_on_beat, clk, rst_n, cmd.write_a || cmd.write_b, req_valid && !req_stall)
    `ASSERT_IMPLIES(a_no_compute_over_result, clk, rst_n, req_valid && !req_stall && func == FUNC_COMPUTE, !rsp_valid)
    `ASSERT_IMPLIES(a_result_after_drain, clk, rst_n, $rose(rsp_valid), !status.pipe_busy)
    `ASSERT_NEXT(a_scan_blocks_input, clk, rst_n, cmd.start, req_stall)

endmodule

`default_nettype wire

// ===== tb/bitmask_overlap_counter_top_tb.sv =====
// bitmask overlap counter testbench: mask writes and overlap counts checked against a local mask model
`timescale 1ns / 1ps

module bitmask_overlap_counter_top_tb;
    import bmoc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int SETTLE = MAX_DIM_DEF + 8;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_A_WIDTH;
    logic [DIM_W-1:0]        cfg_data = '0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic [FUNC_W-1:0]       func = FUNC_WRITE_A;
    logic [COORD_W-1:0]      col = '0;
    logic [COORD_W-1:0]      row = '0;
    logic                    bit_value = 1'b0;
    logic signed [OFS_W-1:0] offset_x = '0;
    logic signed [OFS_W-1:0] offset_y = '0;
    logic                    rsp_valid;
    logic                    rsp_stall = 1'b0;
    logic [COUNT_W-1:0]      overlap_count;

    bit [MAX_DIM_DEF-1:0] a_rows [MAX_DIM_DEF];
    bit [MAX_DIM_DEF-1:0] b_rows [MAX_DIM_DEF];
    bit [MAX_DIM_DEF-1:0] a_known [MAX_DIM_DEF];
    bit [MAX_DIM_DEF-1:0] b_known [MAX_DIM_DEF];
    logic [DIM_W-1:0]     dims [4] = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
    logic [COUNT_W-1:0]   pending_counts [$];
    int                   fail_count = 0;
    bit                   send_idling = 1'b1;
    bit                   rsp_idling = 1'b1;
    int                   hold_request = 0;
    int                   hold_left = 0;

    bitmask_overlap_counter_top dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("[bitmask_overlap_counter_top] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // result side: random stalls plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= rsp_idling && ($urandom_range(99) < 16);
        end
    end

    always @(posedge clk)
    begin : check_counts
        logic [COUNT_W-1:0] want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                report_mismatch("count with nothing outstanding", overlap_count, -1);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (overlap_count !== want)
                    report_mismatch("overlap_count", overlap_count, want);
            end
        end
    end

    function automatic int dim_eff(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
    endfunction

    // intersection of A and the placed B, in A coordinates
    function automatic void overlap_box(input int ox, input int oy,
                                        output int x0, output int x1,
                                        output int y0, output int y1);
        int aw, ah, bw, bh;
        aw = dim_eff(dims[CFG_A_WIDTH]);
        ah = dim_eff(dims[CFG_A_HEIGHT]);
        bw = dim_eff(dims[CFG_B_WIDTH]);
        bh = dim_eff(dims[CFG_B_HEIGHT]);
        x0 = (ox > 0) ? ox : 0;
        y0 = (oy > 0) ? oy : 0;
        x1 = (ox + bw < aw) ? ox + bw : aw;
        y1 = (oy + bh < ah) ? oy + bh : ah;
    endfunction

    function automatic logic [COUNT_W-1:0] predict_overlap(input int ox, input int oy);
        int x0, x1, y0, y1, n;
        overlap_box(ox, oy, x0, x1, y0, y1);
        n = 0;
        for (int j = y0; j < y1; j++)
            for (int i = x0; i < x1; i++)
                n += a_rows[j][i] & b_rows[j - oy][i - ox];
        return n[COUNT_W-1:0];
    endfunction

    function automatic int any_offset();
        return int'($urandom_range(255)) - 128;
    endfunction

    function automatic int next_offset(input int len_a, input int len_b);
        if ($urandom_range(99) < 85)
            return int'($urandom_range(len_a + len_b)) - len_b;
        return any_offset();
    endfunction

    task automatic send_beat(input logic [FUNC_W-1:0] f, input int c, input int r,
                             input bit v, input int ox, input int oy);
        logic signed [OFS_W-1:0] sx, sy;
        sx = ox[OFS_W-1:0];
        sy = oy[OFS_W-1:0];
        if (send_idling && $urandom_range(99) < 9)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        col       <= c[COORD_W-1:0];
        row       <= r[COORD_W-1:0];
        bit_value <= v;
        offset_x  <= sx;
        offset_y  <= sy;
        do @(posedge clk); while (req_stall);
        case (f)
            FUNC_WRITE_A:
            begin
                a_rows[r[COORD_W-1:0]][c[COORD_W-1:0]] = v;
                a_known[r[COORD_W-1:0]][c[COORD_W-1:0]] = 1'b1;
            end
            FUNC_WRITE_B:
            begin
                b_rows[r[COORD_W-1:0]][c[COORD_W-1:0]] = v;
                b_known[r[COORD_W-1:0]][c[COORD_W-1:0]] = 1'b1;
            end
            FUNC_COMPUTE: pending_counts.push_back(predict_overlap(sx, sy));
            default: ;
        endcase
    endtask

    task automatic drain_results(input int settle);
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_counts.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_dims(input int aw, input int ah, input int bw, input int bh);
        logic [CFG_IDX_W-1:0] regs [4];
        int vals [4];
        regs = '{CFG_A_WIDTH, CFG_A_HEIGHT, CFG_B_WIDTH, CFG_B_HEIGHT};
        vals = '{aw, ah, bw, bh};
        drain_results(SETTLE);
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k][DIM_W-1:0];
            @(posedge clk);
            dims[regs[k]] = vals[k][DIM_W-1:0];
        end
        cfg_we <= 1'b0;
    endtask

    // load any mask bit the next count would read before it was ever written, then send the compute beat
    task automatic compute_at(input int ox, input int oy);
        int x0, x1, y0, y1;
        overlap_box(ox, oy, x0, x1, y0, y1);
        for (int j = y0; j < y1; j++)
        begin
            for (int i = x0; i < x1; i++)
            begin
                if (!a_known[j][i])
                    send_beat(FUNC_WRITE_A, i, j, $urandom_range(1), any_offset(), any_offset());
                if (!b_known[j - oy][i - ox])
                    send_beat(FUNC_WRITE_B, i - ox, j - oy, $urandom_range(1),
                              any_offset(), any_offset());
            end
        end
        send_beat(FUNC_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom_range(1),
                  ox, oy);
    endtask

    task automatic compute_random();
        compute_at(next_offset(dim_eff(dims[CFG_A_WIDTH]), dim_eff(dims[CFG_B_WIDTH])),
                   next_offset(dim_eff(dims[CFG_A_HEIGHT]), dim_eff(dims[CFG_B_HEIGHT])));
    endtask

    task automatic write_random(input bit in_bounds);
        logic [FUNC_W-1:0] f;
        int w, h;
        f = $urandom_range(1) ? FUNC_WRITE_B : FUNC_WRITE_A;
        w = dim_eff((f == FUNC_WRITE_A) ? dims[CFG_A_WIDTH] : dims[CFG_B_WIDTH]);
        h = dim_eff((f == FUNC_WRITE_A) ? dims[CFG_A_HEIGHT] : dims[CFG_B_HEIGHT]);
        if (!in_bounds || w == 0 || h == 0)
        begin
            w = MAX_DIM_DEF;
            h = MAX_DIM_DEF;
        end
        send_beat(f, $urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(1),
                  any_offset(), any_offset());
    endtask

    task automatic test_corners();
        send_beat(FUNC_WRITE_A, 63, 63, 1'b1, -128, 127);
        send_beat(FUNC_WRITE_B, 0, 0, 1'b1, 127, -128);
        compute_at(63, 63);
        send_beat(FUNC_WRITE_A, 63, 63, 1'b0, 0, 0);
        compute_at(63, 63);
        compute_at(-63, -63);
        compute_at(63, -63);
        compute_at(-63, 63);
        // no overlap, edges touching and far away
        compute_at(64, 0);
        compute_at(0, -64);
        compute_at(-128, -128);
        compute_at(127, 127);
        compute_at(-128, 127);
        send_beat(FUNC_NONE, 63, 63, 1'b1, -1, -1);
        send_beat(FUNC_NONE, 0, 0, 1'b0, 0, 0);
    endtask

    task automatic test_dim_extremes();
        set_dims(0, 64, 64, 64);
        compute_at(0, 0);
        set_dims(5, 5, 0, 3);
        compute_at(0, 0);
        // above the maximum saturates
        set_dims(127, 1, 127, 1);
        compute_at(0, 0);
        compute_at(1, 0);
        compute_at(-1, 0);
        set_dims(1, 127, 1, 127);
        compute_at(0, 0);
        compute_at(0, 5);
        set_dims(1, 1, 1, 1);
        compute_at(0, 0);
        compute_at(1, 0);
        compute_at(0, -1);
    endtask

    task automatic test_backpressure();
        set_dims(8, 8, 8, 8);
        send_idling = 1'b0;
        hold_request = 300;
        for (int k = 0; k < 36; k++)
        begin
            if (k % 3 == 2)
                compute_random();
            else
                write_random(1'b1);
        end
        drain_results(0);
        hold_request = 120;
        for (int k = 0; k < 20; k++)
        begin
            if (k % 2 == 1)
                compute_random();
            else
                write_random(1'b1);
        end
        send_idling = 1'b1;
    endtask

    task automatic test_random_mix();
        int pick;
        for (int p = 0; p < 12; p++)
        begin
            send_idling = !(p == 2 || p == 3);
            rsp_idling  = !(p == 2 || p == 3);
            if (p % 4 == 3)
            begin
                if ($urandom_range(1))
                    set_dims($urandom_range(32, 127), $urandom_range(1, 4),
                             $urandom_range(32, 127), $urandom_range(1, 4));
                else
                    set_dims($urandom_range(1, 4), $urandom_range(32, 127),
                             $urandom_range(1, 4), $urandom_range(32, 127));
            end
            else
            begin
                set_dims(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12),
                         ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12),
                         ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12),
                         ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12));
            end
            for (int k = 0; k < 45; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 62)
                    write_random(1'b1);
                else if (pick < 68)
                    write_random(1'b0);
                else if (pick < 71)
                    send_beat(FUNC_NONE, $urandom_range(63), $urandom_range(63),
                              $urandom_range(1), any_offset(), any_offset());
                else if (pick < 72)
                    drain_results(0);
                else
                    compute_random();
            end
        end
        send_idling = 1'b1;
        rsp_idling  = 1'b1;
    endtask

    initial
    begin
        int wait_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_corners();
        test_dim_extremes();
        test_backpressure();
        test_random_mix();
        req_valid <= 1'b0;
        for (wait_cycles = 0; pending_counts.size() != 0 && wait_cycles < 20000; wait_cycles++)
            @(posedge clk);
        while (pending_counts.size() != 0)
            report_mismatch("count never arrived", -1, pending_counts.pop_front());
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("[bitmask_overlap_counter_top] OK");
        else
            $display("[bitmask_overlap_counter_top] ERROR");
        $finish;
    end

endmodule

// ===== bitmask_overlap_counter_top.f =====
+incdir+src
src/bmoc_pkg.sv
src/bmoc_ram.sv
src/bmoc_datapath.sv
src/bmoc_ctrl.sv
src/bitmask_overlap_counter_top.sv
tb/bitmask_overlap_counter_top_tb.sv
